>>> hw/rtl/clock_page_replacement_defines.svh
// assertion helpers for the clock page replacement controller
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cpr_pkg.sv
package cpr_pkg;

	// widest frame index over the supported frame range
	localparam int SLOT_MAX_W = 6;
	localparam int SLOT_OUT_W = 4;
	localparam int CFG_W      = 5;
	localparam int FAULT_W    = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef struct packed {
		logic                  rd_en;
		logic [SLOT_MAX_W-1:0] rd_addr;
		logic                  wr_en;
		logic [SLOT_MAX_W-1:0] wr_addr;
	} mem_cmd_t;

	typedef struct packed {
		logic                  rd_valid;
		logic                  match;
		logic [SLOT_MAX_W-1:0] addr;
	} mem_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_EVICT
	} ctrl_state_t;

endpackage

>>> hw/rtl/cpr_frame_store.sv
module cpr_frame_store #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cpr_pkg::mem_cmd_t       cmd,
	input  logic [PAGE_BITS-1:0]    wr_data,
	input  logic [PAGE_BITS-1:0]    key,
	output cpr_pkg::mem_rsp_t       rsp,
	output logic [PAGE_BITS-1:0]    rd_data
);

	localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	// resident page per frame, no reset
	logic [PAGE_BITS-1:0] mem [FRAMES];

	logic [PAGE_BITS-1:0]          rd_data_s1;
	logic                          rd_valid_s1;
	logic [cpr_pkg::SLOT_MAX_W-1:0] rd_addr_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr[SLOT_W-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[cmd.rd_addr[SLOT_W-1:0]];
			rd_addr_s1 <= cmd.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
		end
	end

	assign rd_data      = rd_data_s1;
	assign rsp.rd_valid = rd_valid_s1;
	assign rsp.match    = (rd_data_s1 == key);
	assign rsp.addr     = rd_addr_s1;

endmodule

>>> hw/rtl/cpr_ctrl.sv
`include "clock_page_replacement_defines.svh"

module cpr_ctrl #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16,
	localparam int CNT_W    = $clog2(FRAMES + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [PAGE_BITS-1:0]            page_number,
	input  logic [CNT_W-1:0]                active_n,
	output cpr_pkg::mem_cmd_t               cmd,
	output logic [PAGE_BITS-1:0]            wr_data,
	input  cpr_pkg::mem_rsp_t               rsp,
	input  logic [PAGE_BITS-1:0]            rd_data,
	output logic                            done,
	output logic                            hit,
	output logic                            fault,
	output logic [cpr_pkg::SLOT_OUT_W-1:0]  frame_slot,
	output logic                            evicted_valid,
	output logic [PAGE_BITS-1:0]            evicted_page,
	output logic [cpr_pkg::FAULT_W-1:0]     fault_total
);

	localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	cpr_pkg::ctrl_state_t state_q, state_d;

	logic [PAGE_BITS-1:0]          page_q;
	logic [CNT_W-1:0]              scan_idx_q;
	logic [CNT_W-1:0]              filled_q;
	logic [SLOT_W-1:0]             hand_q;
	logic [FRAMES-1:0]             use_q;
	logic [cpr_pkg::FAULT_W-1:0]   fault_cnt_q;
	logic                          done_q;
	logic                          hit_q;
	logic                          fault_q;
	logic [cpr_pkg::SLOT_OUT_W-1:0] slot_q;
	logic [PAGE_BITS-1:0]          evicted_q;

	logic [CNT_W-1:0]              used;
	logic                          has_free;
	logic                          scan_hit;
	logic                          scan_miss;
	logic [SLOT_W-1:0]             hand_norm;
	logic [SLOT_W-1:0]             hand_inc;
	logic [SLOT_W-1:0]             hit_slot;
	logic [SLOT_W-1:0]             fill_slot;
	logic                          finish;
	logic [cpr_pkg::SLOT_MAX_W-1:0] slot_wide;

	assign used      = (filled_q < active_n) ? filled_q : active_n;
	assign has_free  = (filled_q < active_n);
	assign scan_hit  = (state_q == cpr_pkg::ST_SCAN) && rsp.rd_valid && rsp.match;
	assign scan_miss = (state_q == cpr_pkg::ST_SCAN) && !rsp.rd_valid && (scan_idx_q >= used);
	assign hand_norm = (CNT_W'(hand_q) >= active_n) ? '0 : hand_q;
	assign hand_inc  = ((CNT_W'(hand_q) + CNT_W'(1)) == active_n) ? '0 : hand_q + SLOT_W'(1);
	assign hit_slot  = rsp.addr[SLOT_W-1:0];
	assign fill_slot = filled_q[SLOT_W-1:0];
	assign busy      = (state_q != cpr_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpr_pkg::ST_IDLE: begin
				if (start) begin
					state_d = cpr_pkg::ST_SCAN;
				end
			end
			cpr_pkg::ST_SCAN: begin
				if (scan_hit) begin
					state_d = cpr_pkg::ST_IDLE;
				end else if (scan_miss) begin
					state_d = has_free ? cpr_pkg::ST_IDLE : cpr_pkg::ST_SWEEP;
				end
			end
			cpr_pkg::ST_SWEEP: begin
				if (!use_q[hand_q]) begin
					state_d = cpr_pkg::ST_EVICT;
				end
			end
			cpr_pkg::ST_EVICT: begin
				state_d = cpr_pkg::ST_IDLE;
			end
			default: begin
				state_d = cpr_pkg::ST_IDLE;
			end
		endcase
	end

	// memory commands and completion
	always_comb begin
		cmd       = '0;
		finish    = 1'b0;
		slot_wide = '0;
		unique case (state_q)
			cpr_pkg::ST_IDLE: begin
			end
			cpr_pkg::ST_SCAN: begin
				cmd.rd_en   = !scan_hit && (scan_idx_q < used);
				cmd.rd_addr = cpr_pkg::SLOT_MAX_W'(scan_idx_q[SLOT_W-1:0]);
				cmd.wr_en   = scan_miss && has_free;
				cmd.wr_addr = cpr_pkg::SLOT_MAX_W'(fill_slot);
				finish      = scan_hit || (scan_miss && has_free);
				slot_wide   = scan_hit ? cpr_pkg::SLOT_MAX_W'(hit_slot)
				                       : cpr_pkg::SLOT_MAX_W'(fill_slot);
			end
			cpr_pkg::ST_SWEEP: begin
				cmd.rd_en   = !use_q[hand_q];
				cmd.rd_addr = cpr_pkg::SLOT_MAX_W'(hand_q);
			end
			cpr_pkg::ST_EVICT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = cpr_pkg::SLOT_MAX_W'(hand_q);
				finish      = 1'b1;
				slot_wide   = cpr_pkg::SLOT_MAX_W'(hand_q);
			end
			default: begin
			end
		endcase
	end

	assign wr_data = page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpr_pkg::ST_IDLE;
			scan_idx_q  <= '0;
			filled_q    <= '0;
			hand_q      <= '0;
			use_q       <= '0;
			fault_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			unique case (state_q)
				cpr_pkg::ST_IDLE: begin
					scan_idx_q <= '0;
				end
				cpr_pkg::ST_SCAN: begin
					if (cmd.rd_en) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (scan_hit) begin
						use_q[hit_slot] <= 1'b1;
					end else if (scan_miss) begin
						if (has_free) begin
							use_q[fill_slot] <= 1'b1;
							filled_q         <= filled_q + CNT_W'(1);
						end else begin
							hand_q <= hand_norm;
						end
					end
				end
				cpr_pkg::ST_SWEEP: begin
					// second chance: clear and move on
					if (use_q[hand_q]) begin
						use_q[hand_q] <= 1'b0;
						hand_q        <= hand_inc;
					end
				end
				cpr_pkg::ST_EVICT: begin
					use_q[hand_q] <= 1'b1;
					hand_q        <= hand_inc;
					if (fault_cnt_q != '1) begin
						fault_cnt_q <= fault_cnt_q + cpr_pkg::FAULT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			page_q <= page_number;
		end
		if (finish) begin
			hit_q     <= scan_hit;
			fault_q   <= (state_q == cpr_pkg::ST_EVICT);
			slot_q    <= slot_wide[cpr_pkg::SLOT_OUT_W-1:0];
			evicted_q <= (state_q == cpr_pkg::ST_EVICT) ? rd_data : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign fault         = fault_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = fault_q;
	assign evicted_page  = evicted_q;
	assign fault_total   = fault_cnt_q;

	`CPR_ASSERT_NOW(a_hit_fault_excl, done_q, !(hit_q && fault_q), "hit and fault together")
	`CPR_ASSERT_NOW(a_evict_zero, done_q && !fault_q, evicted_q == '0, "eviction without fault")
	`CPR_ASSERT_NOW(a_hand_range, state_q == cpr_pkg::ST_SWEEP, CNT_W'(hand_q) < active_n,
		"hand outside active frames")
	`CPR_ASSERT_NOW(a_fill_bound, 1'b1, filled_q <= CNT_W'(FRAMES), "fill count overflow")
	`CPR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction not started")

endmodule

>>> hw/rtl/clock_page_replacement.sv
// clock (second-chance) page replacement, one page reference per transaction
// sequence: a hit ends the lookup scan, a miss with a free frame fills that frame,
//   and a fault runs the lookup, then the hand sweep, then the eviction
// throughput: one transaction at a time, the next accepted in the cycle the result is strobed
// reset: use bits, fill count, hand and fault count cleared, frame_count back to 16;
//   frame ram is not cleared, results are strobed once and cannot be stalled
module clock_page_replacement #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            start,
	output logic                            busy,
	input  logic [PAGE_BITS-1:0]            page_number,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cpr_pkg::CFG_W-1:0]       cfg_data,
	// result strobe and fields
	output logic                            done,
	output logic                            hit,
	output logic                            fault,
	output logic [cpr_pkg::SLOT_OUT_W-1:0]  frame_slot,
	output logic                            evicted_valid,
	output logic [PAGE_BITS-1:0]            evicted_page,
	output logic [cpr_pkg::FAULT_W-1:0]     fault_total
);

	localparam int CNT_W = $clog2(FRAMES + 1);
	// comparison width covering both the register and the frame count
	localparam int CMP_W = (CNT_W > cpr_pkg::CFG_W) ? CNT_W : cpr_pkg::CFG_W;

	logic [cpr_pkg::CFG_W-1:0] frame_count_q;
	logic [CMP_W-1:0]          cfg_ext;
	logic [CNT_W-1:0]          active_n;

	cpr_pkg::mem_cmd_t    cmd;
	cpr_pkg::mem_rsp_t    rsp;
	logic [PAGE_BITS-1:0] wr_data;
	logic [PAGE_BITS-1:0] rd_data;

	// frame count only changes between transactions
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= cpr_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frame_count_q <= cfg_data;
		end
	end

	// zero behaves as one frame, anything above the build size as the build size
	assign cfg_ext = CMP_W'(frame_count_q);

	always_comb begin
		if (cfg_ext == '0) begin
			active_n = CNT_W'(1);
		end else if (cfg_ext > CMP_W'(FRAMES)) begin
			active_n = CNT_W'(FRAMES);
		end else begin
			active_n = cfg_ext[CNT_W-1:0];
		end
	end

	// sequencer: lookup scan, fill, hand sweep and eviction
	cpr_ctrl #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.page_number   (page_number),
		.active_n      (active_n),
		.cmd           (cmd),
		.wr_data       (wr_data),
		.rsp           (rsp),
		.rd_data       (rd_data),
		.done          (done),
		.hit           (hit),
		.fault         (fault),
		.frame_slot    (frame_slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

	// resident page ram with registered read and compare against the reference
	cpr_frame_store #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_frame_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_data (wr_data),
		.key     (wr_data),
		.rsp     (rsp),
		.rd_data (rd_data)
	);

endmodule

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAMES      = 16;
	localparam int PAGE_BITS   = 16;
	// run limit, leaving plenty of headroom over the worst transaction
	localparam int CYCLE_LIMIT = 400000;
	// settle time covers a fault: lookup, full sweep and eviction
	localparam int SETTLE      = 2 * FRAMES + 8;
	localparam int SEG_ITEMS   = 71;

	// one expected page reference outcome
	typedef struct {
		logic                           hit;
		logic                           fault;
		logic [cpr_pkg::SLOT_OUT_W-1:0] frame_slot;
		logic                           evicted_valid;
		logic [PAGE_BITS-1:0]           evicted_page;
		logic [cpr_pkg::FAULT_W-1:0]    fault_total;
	} page_outcome_t;

	logic                           clk;
	logic                           arst_n      = 1'b0;
	logic                           start       = 1'b0;
	logic                           busy;
	logic [PAGE_BITS-1:0]           page_number = '0;
	logic                           cfg_valid   = 1'b0;
	logic                           cfg_ready;
	logic [cpr_pkg::CFG_W-1:0]      cfg_data    = cpr_pkg::CFG_RESET;
	logic                           done;
	logic                           hit;
	logic                           fault;
	logic [cpr_pkg::SLOT_OUT_W-1:0] frame_slot;
	logic                           evicted_valid;
	logic [PAGE_BITS-1:0]           evicted_page;
	logic [cpr_pkg::FAULT_W-1:0]    fault_total;

	// page references waiting to be driven, outcomes waiting to be strobed
	logic [PAGE_BITS-1:0] page_backlog[$];
	page_outcome_t        outcome_queue[$];
	// working set of the current segment, so that hits and faults both occur
	logic [PAGE_BITS-1:0] hot_pages[$];

	int send_idle_pct = 12;
	int mismatch_count = 0;
	int cycle_count = 0;

	// mirror of the frame table
	logic [cpr_pkg::CFG_W-1:0]   frame_count_reg = cpr_pkg::CFG_RESET;
	logic [PAGE_BITS-1:0]        resident_page[FRAMES];
	bit                          use_flag[FRAMES];
	int                          fill_level;
	int                          hand_pos;
	logic [cpr_pkg::FAULT_W-1:0] faults_seen;

	clock_page_replacement #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.page_number  (page_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.hit          (hit),
		.fault        (fault),
		.frame_slot   (frame_slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_total  (fault_total)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// second-chance replacement on the mirrored frame table
	function automatic page_outcome_t reference_page(input logic [PAGE_BITS-1:0] pg);
		page_outcome_t r;
		int n;
		int used;
		int slot;
		int guard;
		bit found;
		// out-of-range counts: zero acts as one, anything above FRAMES as FRAMES
		n = (frame_count_reg == 0) ? 1 :
			(int'(frame_count_reg) > FRAMES) ? FRAMES : int'(frame_count_reg);
		used = (fill_level < n) ? fill_level : n;
		found = 1'b0;
		slot = 0;
		// lowest matching frame wins when a page sits in two frames
		for (int i = 0; i < used; i++) begin
			if (!found && resident_page[i] == pg) begin
				found = 1'b1;
				slot = i;
			end
		end
		r.hit = found;
		r.fault = 1'b0;
		r.evicted_page = '0;
		if (found) begin
			use_flag[slot] = 1'b1;
		end else if (fill_level < n) begin
			// free frame: plain append, not a fault
			slot = fill_level;
			resident_page[slot] = pg;
			use_flag[slot] = 1'b1;
			fill_level++;
		end else begin
			r.fault = 1'b1;
			if (faults_seen != '1)
				faults_seen++;
			// hand left beyond a lowered count restarts at frame zero
			if (hand_pos >= n)
				hand_pos = 0;
			for (guard = 0; guard <= n && use_flag[hand_pos]; guard++) begin
				use_flag[hand_pos] = 1'b0;
				hand_pos = (hand_pos + 1) % n;
			end
			slot = hand_pos;
			r.evicted_page = resident_page[slot];
			resident_page[slot] = pg;
			use_flag[slot] = 1'b1;
			hand_pos = (hand_pos + 1) % n;
		end
		r.frame_slot = slot[cpr_pkg::SLOT_OUT_W-1:0];
		r.evicted_valid = r.fault;
		r.fault_total = faults_seen;
		return r;
	endfunction

	// queue a page reference behind the ones already waiting
	task automatic add_page(input logic [PAGE_BITS-1:0] pg);
		page_backlog.insert(page_backlog.size(), pg);
	endtask

	// driver: a transaction is taken when start is high and busy low
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				outcome_queue.insert(outcome_queue.size(), reference_page(page_number));
			// the command slot is free, so either offer the next page or idle
			if (!start || !busy) begin
				if (page_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					start <= 1'b1;
					page_number <= page_backlog.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every done strobe is checked against the oldest outcome
	always @(posedge clk) begin
		page_outcome_t exp_o;
		if (arst_n && done) begin
			if (outcome_queue.size() == 0) begin
				$error("result strobed with no page reference outstanding");
				mismatch_count++;
			end else begin
				exp_o = outcome_queue.pop_front();
				if (hit !== exp_o.hit) begin
					$error("hit: expected %0d, got %0d", exp_o.hit, hit);
					mismatch_count++;
				end
				if (fault !== exp_o.fault) begin
					$error("fault: expected %0d, got %0d", exp_o.fault, fault);
					mismatch_count++;
				end
				if (frame_slot !== exp_o.frame_slot) begin
					$error("frame_slot: expected %0d, got %0d", exp_o.frame_slot, frame_slot);
					mismatch_count++;
				end
				if (evicted_valid !== exp_o.evicted_valid) begin
					$error("evicted_valid: expected %0d, got %0d",
						exp_o.evicted_valid, evicted_valid);
					mismatch_count++;
				end
				if (evicted_page !== exp_o.evicted_page) begin
					$error("evicted_page: expected 0x%0h, got 0x%0h",
						exp_o.evicted_page, evicted_page);
					mismatch_count++;
				end
				if (fault_total !== exp_o.fault_total) begin
					$error("fault_total: expected %0d, got %0d", exp_o.fault_total, fault_total);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// block until every page has been driven and every outcome has come back
	task automatic wait_drained();
		while (page_backlog.size() > 0 || start || outcome_queue.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// single register write, only ever issued with the block idle
	task automatic write_frame_count(input logic [cpr_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		frame_count_reg = value;
		cfg_valid <= 1'b0;
	endtask

	// random working set sized around the active frame count
	task automatic pick_hot_pages();
		int n;
		int sz;
		n = (frame_count_reg == 0) ? 1 :
			(int'(frame_count_reg) > FRAMES) ? FRAMES : int'(frame_count_reg);
		sz = $urandom_range(n + 3, 1);
		hot_pages.delete();
		repeat (sz) hot_pages.insert(hot_pages.size(), PAGE_BITS'($urandom));
	endtask

	// one configuration, then a burst of references mostly from the working set
	task automatic run_segment(input logic [cpr_pkg::CFG_W-1:0] value);
		int roll;
		write_frame_count(value);
		pick_hot_pages();
		repeat (SEG_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 80)
				add_page(hot_pages[$urandom_range(hot_pages.size() - 1)]);
			else if (roll < 92)
				add_page(PAGE_BITS'($urandom));
			else if (roll < 96)
				add_page('0);
			else
				add_page('1);
		end
		wait_drained();
	endtask

	initial begin
		logic [cpr_pkg::CFG_W-1:0] phase_a[4];
		logic [cpr_pkg::CFG_W-1:0] phase_b[4];
		logic [cpr_pkg::CFG_W-1:0] phase_c[4];

		for (int i = 0; i < FRAMES; i++) begin
			resident_page[i] = '0;
			use_flag[i] = 1'b0;
		end
		fill_level = 0;
		hand_pos = 0;
		faults_seen = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme pages, a repeat hit, fill all 16 frames, then a
		// fault with every use bit set (full sweep), a hit that re-arms a
		// cleared bit, a fault that skips it and a fault on the evicted page
		add_page('0);
		add_page('1);
		add_page('0);
		add_page(16'hAAAA);
		add_page(16'h5555);
		for (int k = 1; k <= 12; k++)
			add_page(PAGE_BITS'(16'h0100 * k + k));
		add_page(16'h1234);
		add_page('1);
		add_page(16'h4321);
		add_page('0);
		wait_drained();

		// shrink, zero (acts as one), above range (acts as full), then a middle value;
		// shrinking and growing again leaves duplicate residents behind
		phase_a = '{5'd2, 5'd0, 5'd31, 5'd5};
		phase_b = '{5'd1, 5'd16, 5'd17, 5'd9};
		phase_c = '{5'd3, cpr_pkg::CFG_W'($urandom_range(31)), 5'd12, 5'd16};

		send_idle_pct = 12;
		foreach (phase_a[i]) run_segment(phase_a[i]);
		send_idle_pct = 68;
		foreach (phase_b[i]) run_segment(phase_b[i]);
		send_idle_pct = 0;
		foreach (phase_c[i]) run_segment(phase_c[i]);

		wait_drained();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
